// ----- rtl/tea_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tea_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned QDEPTH     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CIPHER_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3  = 3'd4;

  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  localparam logic [31:0] TEA_DELTA   = 32'h9E3779B9;
  localparam logic [7:0]  PAD_BYTE    = 8'hFE;
  localparam logic [31:0] KEY0_RESET  = 32'h1337FACE;
  localparam logic [31:0] KEY1_RESET  = 32'h12345678;
  localparam logic [31:0] KEY2_RESET  = 32'hDEADBEEF;
  localparam logic [31:0] KEY3_RESET  = 32'hFEEDABCD;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       flush;
  } tea_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       block_last;
  } tea_out_t;

  typedef struct packed {
    logic        vld;
    logic [63:0] blk;
  } tea_push_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] k0;
    logic [31:0] k1;
    logic [31:0] k2;
    logic [31:0] k3;
  } tea_cfg_t;

  function automatic logic [31:0] tea_mix(input logic [31:0] x, input logic [31:0] sum,
                                          input logic [31:0] ka, input logic [31:0] kb);
    tea_mix = ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tea_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tea_front
  import tea_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      mode,
  input  wire logic      accept,
  input  wire tea_in_t   in_word,
  output tea_push_t      push
);

  logic [2:0] fill_pos_r;
  logic [2:0] fill_pos_nxt;
  logic [7:0] blk_r [8];
  logic [63:0] blk_data;

  always_comb begin
    fill_pos_nxt = fill_pos_r;
    push.vld     = 1'b0;
    blk_data     = '0;
    for (int i = 0; i < 8; i++) begin
      if (in_word.flush) begin
        blk_data[8*i +: 8] = (3'(i) >= fill_pos_r) ? PAD_BYTE : blk_r[i];
      end else begin
        blk_data[8*i +: 8] = (3'(i) == fill_pos_r) ? in_word.data_byte : blk_r[i];
      end
    end
    if (accept) begin
      if (in_word.flush) begin
        if (fill_pos_r != 3'd0) begin
          fill_pos_nxt = 3'd0;
          push.vld     = (mode == MODE_ENCRYPT);
        end
      end else begin
        fill_pos_nxt = fill_pos_r + 3'd1;
        push.vld     = (fill_pos_r == 3'd7);
      end
    end
    push.blk = blk_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_pos_r <= 3'd0;
    end else begin
      fill_pos_r <= fill_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !in_word.flush) begin
      blk_r[fill_pos_r] <= in_word.data_byte;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tea_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tea_fifo
  import tea_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire tea_push_t   push,
  input  wire logic        pop,
  output logic             full,
  output logic             empty,
  output logic [63:0]      rd_data
);

  localparam int unsigned AW = $clog2(QDEPTH);
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  logic [63:0]   mem_r [QDEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt_r == CW'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push.vld && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(QDEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(QDEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.blk;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tea_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tea_back
  import tea_pkg::*;
#(
  parameter int unsigned ROUNDS = 32
)
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire tea_cfg_t    cfg,
  input  wire logic        q_empty,
  input  wire logic [63:0] q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output tea_out_t         out_word
);

  localparam int unsigned RW = $clog2(ROUNDS + 1);
  localparam logic [63:0] SUM_DEC_W = 64'(TEA_DELTA) * 64'(ROUNDS);
  localparam logic [31:0] SUM_DEC = SUM_DEC_W[31:0];

  logic          busy_r;
  logic          busy_nxt;
  logic [RW-1:0] rnd_r;
  logic [RW-1:0] rnd_nxt;
  logic [31:0]   v0_r, v0_nxt;
  logic [31:0]   v1_r, v1_nxt;
  logic [31:0]   sum_r, sum_nxt;
  logic [63:0]   obuf_r, obuf_nxt;
  logic [3:0]    ocnt_r, ocnt_nxt;
  logic          rounds_done;
  logic          out_free;
  logic          load;
  logic          take;
  logic          out_acc;
  logic [31:0]   e0, e1, d0, d1;

  assign out_valid           = (ocnt_r != 4'd0);
  assign out_word.out_byte   = obuf_r[7:0];
  assign out_word.block_last = (ocnt_r == 4'd1);
  assign out_acc             = out_valid && !out_stall;

  assign rounds_done = busy_r && (rnd_r == RW'(ROUNDS));
  assign out_free    = (ocnt_r == 4'd0) || ((ocnt_r == 4'd1) && !out_stall);
  assign load        = rounds_done && out_free;
  assign take        = !busy_r || load;
  assign q_pop       = take && !q_empty;

  assign e0 = v0_r + tea_mix(v1_r, sum_r, cfg.k0, cfg.k1);
  assign e1 = v1_r + tea_mix(e0, sum_r, cfg.k2, cfg.k3);
  assign d1 = v1_r - tea_mix(v0_r, sum_r, cfg.k2, cfg.k3);
  assign d0 = v0_r - tea_mix(d1, sum_r, cfg.k0, cfg.k1);

  always_comb begin
    busy_nxt = busy_r;
    rnd_nxt  = rnd_r;
    v0_nxt   = v0_r;
    v1_nxt   = v1_r;
    sum_nxt  = sum_r;
    obuf_nxt = obuf_r;
    ocnt_nxt = ocnt_r;

    if (out_acc) begin
      obuf_nxt = {8'h00, obuf_r[63:8]};
      ocnt_nxt = ocnt_r - 4'd1;
    end
    if (load) begin
      obuf_nxt = {v1_r, v0_r};
      ocnt_nxt = 4'd8;
    end

    if (take) begin
      busy_nxt = !q_empty;
      rnd_nxt  = '0;
      v0_nxt   = q_data[31:0];
      v1_nxt   = q_data[63:32];
      sum_nxt  = (cfg.mode == MODE_ENCRYPT) ? TEA_DELTA : SUM_DEC;
    end else if (!rounds_done) begin
      rnd_nxt = rnd_r + RW'(1);
      if (cfg.mode == MODE_ENCRYPT) begin
        v0_nxt  = e0;
        v1_nxt  = e1;
        sum_nxt = sum_r + TEA_DELTA;
      end else begin
        v0_nxt  = d0;
        v1_nxt  = d1;
        sum_nxt = sum_r - TEA_DELTA;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= '0;
      ocnt_r <= 4'd0;
    end else begin
      busy_r <= busy_nxt;
      rnd_r  <= rnd_nxt;
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v0_r   <= v0_nxt;
    v1_r   <= v1_nxt;
    sum_r  <= sum_nxt;
    obuf_r <= obuf_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/tea_ecb_byte_stream_cipher.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Port group   Direction   Handshake            Word
// in_*         input       in_valid/in_stall    tea_in_t  (data_byte, flush)
// out_*        output      out_valid/out_stall  tea_out_t (out_byte, block_last)
// cfg_*        input       cfg_we               cfg_index selects, cfg_data is the value
//
// Bytes are taken one per cycle until the two-block queue is full.
// The round unit does one TEA round per cycle, ROUNDS rounds for each block.
// Output bytes leave from an 8-byte buffer while the next block is being ciphered.
// Reset is synchronous and active low; a stalled output holds its word.
module tea_ecb_byte_stream_cipher
  import tea_pkg::*;
#(
  parameter int unsigned ROUNDS = 32
)
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire tea_in_t               in_word,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output tea_out_t                   out_word,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  tea_cfg_t    cfg_r;
  tea_push_t   push;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;
  logic [63:0] q_data;
  logic        in_acc;

  assign in_stall = q_full;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode <= MODE_ENCRYPT;
      cfg_r.k0   <= KEY0_RESET;
      cfg_r.k1   <= KEY1_RESET;
      cfg_r.k2   <= KEY2_RESET;
      cfg_r.k3   <= KEY3_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CIPHER_MODE: cfg_r.mode <= cfg_data[0];
        REG_KEY_WORD_0:  cfg_r.k0   <= cfg_data;
        REG_KEY_WORD_1:  cfg_r.k1   <= cfg_data;
        REG_KEY_WORD_2:  cfg_r.k2   <= cfg_data;
        REG_KEY_WORD_3:  cfg_r.k3   <= cfg_data;
        default: ;
      endcase
    end
  end

  tea_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .mode    (cfg_r.mode),
    .accept  (in_acc),
    .in_word (in_word),
    .push    (push)
  );

  tea_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .pop     (q_pop),
    .full    (q_full),
    .empty   (q_empty),
    .rd_data (q_data)
  );

  tea_back #(
    .ROUNDS (ROUNDS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    push.vld |-> !q_full)
    else $error("block pushed into a full queue");

  a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push.vld |-> in_acc)
    else $error("block pushed without an accepted input word");

  a_out_ends_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(out_word.block_last) && !$past(out_stall))
    else $error("output stream stopped inside a block");

endmodule

`default_nettype wire
